// File: hdl/kal_pkg.sv
package kal_pkg;

    // Fraction bits of the AR coefficient (fixed, independent of FRAC_BITS)
    localparam int GAIN_FRAC = 16;
    localparam int G2_W      = 18;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AR_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATE_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_NOISE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OBS_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VAR = 3'd4;

    // Reset values of the configuration registers
    localparam logic [16:0]        AR_GAIN_RST     = 17'd58982;
    localparam logic [30:0]        STATE_NOISE_RST = 31'd65536;
    localparam logic [30:0]        OBS_NOISE_RST   = 31'd65536;
    localparam logic signed [31:0] OBS_OFFSET_RST  = 32'sd0;
    localparam logic [30:0]        INITIAL_VAR_RST = 31'd65536;

    localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32_MIN = -64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] U31_MAX = 64'sh0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] sample;
        logic signed [31:0] drive;
        logic               first;
    } kal_in_t;

    typedef struct packed {
        logic signed [31:0] filtered_mean;
        logic [30:0]        filtered_var;
        logic signed [31:0] predicted_mean;
        logic [30:0]        predicted_var;
        logic               saturated;
    } kal_out_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } sat_t;

    // Clamp to the signed 32-bit range
    function automatic sat_t sat_s32(input logic signed [63:0] x);
        sat_t r;
        r.clip = 1'b0;
        r.val  = x[31:0];
        if (x > S32_MAX)
        begin
            r.clip = 1'b1;
            r.val  = S32_MAX[31:0];
        end
        else if (x < S32_MIN)
        begin
            r.clip = 1'b1;
            r.val  = S32_MIN[31:0];
        end
        return r;
    endfunction

    // Clamp a non-negative value to 2^31-1
    function automatic sat_t sat_u31(input logic signed [63:0] x);
        sat_t r;
        r.clip = 1'b0;
        r.val  = x[31:0];
        if (x > U31_MAX)
        begin
            r.clip = 1'b1;
            r.val  = U31_MAX[31:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/kal_mul.sv
module kal_mul #(
    parameter int AW = 34,
    parameter int BW = 19
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] prod
);

    // Shared signed multiplier, product registered
    logic signed [AW+BW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: hdl/kal_div.sv
module kal_div #(
    parameter int QW = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [30:0]           num,
    input  logic [31:0]           den,
    output kal_pkg::div_stat_t    stat,
    output logic [QW-1:0]         quo
);
    import kal_pkg::*;

    // Restoring divider for (num << (QW-1)) / den, one quotient bit per cycle.
    // The start cycle settles the integer bit, then QW-1 fraction steps follow.
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] STEPS = CW'(QW - 1);

    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;
    logic        ge0;

    // Integer bit at start
    assign ge0 = {1'b0, num} >= den;

    // One shift, compare and subtract step
    always_comb
    begin
        trial = {rem_reg, 1'b0};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            quo_reg <= {{(QW-1){1'b0}}, ge0};
            rem_reg <= ge0 ? {1'b0, num - den[30:0]} : {1'b0, num};
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QW-2:0], ge};
            rem_reg <= ge ? diff[31:0] : trial[31:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

    // A new division never starts on top of a running one
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

// File: hdl/scalar_kalman_forward_filter.sv
// One sample is processed at a time; the sample rate is limited by the one-bit-per-cycle
// gain divider and the single shared multiplier, and the division is skipped when the
// gain denominator is zero. A new sample is accepted only in the idle state. Values are Q16.16 by default.
// The next sample is taken while the last result still waits in the output register.
// Reset (rst_n, asynchronous, active low) loads the register defaults, mean 0 and
// variance equal to the default initial variance.
module scalar_kalman_forward_filter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  kal_pkg::kal_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output kal_pkg::kal_out_t            out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import kal_pkg::*;

    localparam int KW = FRAC_BITS + 1;
    localparam int AW = 34;
    localparam int BW = (KW + 1 > G2_W + 1) ? KW + 1 : G2_W + 1;
    localparam int PW = AW + BW;
    localparam logic [KW-1:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GG   = 4'd1;
    localparam logic [3:0] S_GM   = 4'd2;
    localparam logic [3:0] S_GV   = 4'd3;
    localparam logic [3:0] S_PV   = 4'd4;
    localparam logic [3:0] S_DEN  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_KI   = 4'd7;
    localparam logic [3:0] S_OV   = 4'd8;
    localparam logic [3:0] S_NV   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    // Configuration
    logic [16:0]        ar_gain_reg;
    logic [30:0]        state_noise_var_reg;
    logic [30:0]        obs_noise_var_reg;
    logic signed [31:0] obs_offset_reg;
    logic [30:0]        initial_var_reg;

    // Filter state
    logic signed [31:0] mean_reg;
    logic [30:0]        var_reg;

    // Working registers
    logic signed [31:0] y_reg;
    logic signed [31:0] drive_reg;
    logic [G2_W-1:0]    g2_reg;
    logic signed [31:0] pm_reg;
    logic [30:0]        pv_reg;
    logic signed [33:0] innov_reg;
    logic [KW-1:0]      k_reg;
    logic signed [31:0] nm_reg;
    logic [30:0]        nv_reg;
    logic               clip_reg;
    logic               out_valid_reg;
    kal_out_t           out_reg;

    logic in_fire;
    logic cfg_fire;
    logic out_free;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [63:0]   prod_ext;

    sat_t               pm_sat;
    sat_t               pv_sat;
    sat_t               nm_sat;
    sat_t               nv_sat;
    logic [31:0]        den;
    logic signed [33:0] innov;

    logic               div_start;
    div_stat_t          div_stat;
    logic [KW-1:0]      div_quo;

    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_GG:
            begin
                mul_a = {{(AW-17){1'b0}}, ar_gain_reg};
                mul_b = {{(BW-17){1'b0}}, ar_gain_reg};
            end
            S_GM:
            begin
                mul_a = {{(AW-32){mean_reg[31]}}, mean_reg};
                mul_b = {{(BW-17){1'b0}}, ar_gain_reg};
            end
            S_GV:
            begin
                mul_a = {{(AW-31){1'b0}}, var_reg};
                mul_b = {{(BW-G2_W){1'b0}}, g2_reg};
            end
            S_KI:
            begin
                mul_a = innov_reg;
                mul_b = {{(BW-KW){1'b0}}, k_reg};
            end
            S_OV:
            begin
                mul_a = {{(AW-31){1'b0}}, obs_noise_var_reg};
                mul_b = {{(BW-KW){1'b0}}, k_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    kal_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    kal_div #(
        .QW (KW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pv_reg),
        .den   (den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // Post-multiply arithmetic; signed sums keep the shifts arithmetic
    always_comb
    begin
        prod_ext = {{(64-PW){prod[PW-1]}}, prod};
        pm_sat   = sat_s32((prod_ext >>> GAIN_FRAC)
                           + $signed({{32{drive_reg[31]}}, drive_reg}));
        pv_sat   = sat_u31((prod_ext >>> GAIN_FRAC)
                           + {33'd0, state_noise_var_reg});
        nm_sat   = sat_s32((prod_ext >>> FRAC_BITS)
                           + $signed({{32{pm_reg[31]}}, pm_reg}));
        nv_sat   = sat_u31(prod_ext >>> FRAC_BITS);
        den      = {1'b0, pv_reg} + {1'b0, obs_noise_var_reg};
        innov    = {{2{y_reg[31]}}, y_reg}
                   - {{2{obs_offset_reg[31]}}, obs_offset_reg}
                   - {{2{pm_reg[31]}}, pm_reg};
    end

    assign div_start = (state_reg == S_DEN) && (den != 32'd0);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_GG;
            S_GG:   state_next = S_GM;
            S_GM:   state_next = S_GV;
            S_GV:   state_next = S_PV;
            S_PV:   state_next = S_DEN;
            S_DEN:  state_next = (den != 32'd0) ? S_DIV : S_KI;
            S_DIV:  if (div_stat.done) state_next = S_KI;
            S_KI:   state_next = S_OV;
            S_OV:   state_next = S_NV;
            S_NV:   state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            out_valid_reg       <= 1'b0;
            clip_reg            <= 1'b0;
            mean_reg            <= '0;
            var_reg             <= INITIAL_VAR_RST;
            ar_gain_reg         <= AR_GAIN_RST;
            state_noise_var_reg <= STATE_NOISE_RST;
            obs_noise_var_reg   <= OBS_NOISE_RST;
            obs_offset_reg      <= OBS_OFFSET_RST;
            initial_var_reg     <= INITIAL_VAR_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_AR_GAIN:     ar_gain_reg         <= cfg_data[16:0];
                    REG_STATE_NOISE: state_noise_var_reg <= cfg_data[30:0];
                    REG_OBS_NOISE:   obs_noise_var_reg   <= cfg_data[30:0];
                    REG_OBS_OFFSET:  obs_offset_reg      <= cfg_data;
                    REG_INITIAL_VAR: initial_var_reg     <= cfg_data[30:0];
                    default: ;
                endcase
            end

            // Restart before prediction
            if (in_fire && in_data.first)
            begin
                mean_reg <= '0;
                var_reg  <= initial_var_reg;
            end

            // Clip flag gathers over the step
            if (in_fire)
                clip_reg <= 1'b0;
            else if ((state_reg == S_GV && pm_sat.clip)
                     || (state_reg == S_PV && pv_sat.clip)
                     || (state_reg == S_OV && nm_sat.clip)
                     || (state_reg == S_NV && nv_sat.clip))
                clip_reg <= 1'b1;

            // Output slot and state commit
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                mean_reg      <= nm_reg;
                var_reg       <= nv_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            y_reg     <= in_data.sample;
            drive_reg <= in_data.drive;
        end

        unique case (state_reg)
            S_GM:   g2_reg    <= prod[GAIN_FRAC +: G2_W];
            S_GV:   pm_reg    <= pm_sat.val;
            S_PV:   pv_reg    <= pv_sat.val[30:0];
            S_DEN:
            begin
                innov_reg <= innov;
                if (den == 32'd0)
                    k_reg <= '0;
            end
            S_DIV:  if (div_stat.done) k_reg <= div_quo;
            S_OV:   nm_reg    <= nm_sat.val;
            S_NV:   nv_reg    <= nv_sat.val[30:0];
            S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.filtered_mean  <= nm_reg;
                    out_reg.filtered_var   <= nv_reg;
                    out_reg.predicted_mean <= pm_reg;
                    out_reg.predicted_var  <= pv_reg;
                    out_reg.saturated      <= clip_reg;
                end
            end
            default: ;
        endcase
    end

    // Updated variance is K times the observation noise with K at most one
    a_var_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.filtered_var <= obs_noise_var_reg)
        else $error("filtered variance above observation noise");

    // Gain numerator never exceeds its denominator
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> div_quo <= K_ONE)
        else $error("Kalman gain above one");

    // The sequencer never waits on an idle divider
    a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_stat.busy || div_stat.done)
        else $error("waiting on a divider that is not running");

    // Mean changes only on restart or at commit
    a_mean_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(mean_reg) |-> $past(state_reg == S_DONE || in_fire))
        else $error("filter mean changed outside commit");

endmodule

// File: test/kalman_filter_checker.sv
`timescale 1ns / 100ps

// Watches the sample, result and register channels, keeps its own copy of the
// filter state and compares every result transfer with the oldest estimate.
module kalman_filter_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  kal_pkg::kal_in_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  kal_pkg::kal_out_t             out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import kal_pkg::*;

    localparam longint S32_HI     = 64'sd2147483647;
    localparam longint S32_LO     = -64'sd2147483648;
    localparam longint U31_HI     = 64'sd2147483647;

    // Shadow copy of the settings
    logic [16:0]        gain;
    logic [30:0]        q_state;
    logic [30:0]        r_obs;
    logic signed [31:0] offset;
    logic [30:0]        p_init;

    // Filtered mean and variance as the block should hold them
    logic signed [31:0] mean_q;
    logic [30:0]        var_q;

    kal_out_t estimates[$];
    int       mismatches   = 0;
    int       outstanding  = 0;
    int       results_seen = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    // One line per bad result
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] checker: %s", $time, msg);
    endtask

    function automatic longint clamp_s32(input longint a);
        if (a > S32_HI)
            return S32_HI;
        if (a < S32_LO)
            return S32_LO;
        return a;
    endfunction

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        case (idx)
            REG_AR_GAIN:     gain    = val[16:0];
            REG_STATE_NOISE: q_state = val[30:0];
            REG_OBS_NOISE:   r_obs   = val[30:0];
            REG_OBS_OFFSET:  offset  = val;
            REG_INITIAL_VAR: p_init  = val[30:0];
            default: ;
        endcase
    endtask

    // One predict/update step; queues the estimate and moves the state on
    task automatic advance_filter(input kal_in_t x);
        longint   m, v, pm, g2, pv, den, k, innov, nm, nv;
        bit       clip;
        kal_out_t e;

        // restart loads mean 0 and the current initial variance
        m = x.first ? 64'sd0 : longint'(mean_q);
        v = x.first ? longint'(p_init) : longint'(var_q);
        clip = 1'b0;

        // prediction, gain always in Q1.16
        pm = ((longint'(gain) * m) >>> GAIN_FRAC) + longint'($signed(x.drive));
        clip |= (pm != clamp_s32(pm));
        pm = clamp_s32(pm);

        g2 = (longint'(gain) * longint'(gain)) >> GAIN_FRAC;
        pv = ((g2 * v) >> GAIN_FRAC) + longint'(q_state);
        if (pv > U31_HI)
        begin
            pv   = U31_HI;
            clip = 1'b1;
        end

        // Kalman gain; a zero denominator gives no correction at all
        den = pv + longint'(r_obs);
        k   = (den == 0) ? 64'sd0 : (pv <<< FRAC_BITS) / den;

        // update, innovation kept at full width
        innov = longint'($signed(x.sample)) - longint'(offset) - pm;
        nm    = pm + ((k * innov) >>> FRAC_BITS);
        clip |= (nm != clamp_s32(nm));
        nm    = clamp_s32(nm);

        nv = (longint'(r_obs) * k) >> FRAC_BITS;
        if (nv > U31_HI)
        begin
            nv   = U31_HI;
            clip = 1'b1;
        end

        mean_q = nm[31:0];
        var_q  = nv[30:0];

        e.filtered_mean  = nm[31:0];
        e.filtered_var   = nv[30:0];
        e.predicted_mean = pm[31:0];
        e.predicted_var  = pv[30:0];
        e.saturated      = clip;
        estimates.push_back(e);
    endtask

    task automatic check_result(input kal_out_t got);
        kal_out_t want;
        string    diffs;

        results_seen++;
        if (estimates.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none outstanding", results_seen));
            return;
        end
        want  = estimates.pop_front();
        diffs = "";
        if (got.filtered_mean !== want.filtered_mean)
            diffs = {diffs, $sformatf(" filtered_mean %0d/%0d",
                                      got.filtered_mean, want.filtered_mean)};
        if (got.filtered_var !== want.filtered_var)
            diffs = {diffs, $sformatf(" filtered_var %0d/%0d",
                                      got.filtered_var, want.filtered_var)};
        if (got.predicted_mean !== want.predicted_mean)
            diffs = {diffs, $sformatf(" predicted_mean %0d/%0d",
                                      got.predicted_mean, want.predicted_mean)};
        if (got.predicted_var !== want.predicted_var)
            diffs = {diffs, $sformatf(" predicted_var %0d/%0d",
                                      got.predicted_var, want.predicted_var)};
        if (got.saturated !== want.saturated)
            diffs = {diffs, $sformatf(" saturated %0b/%0b", got.saturated, want.saturated)};
        if (diffs != "")
            report_mismatch($sformatf("result %0d (got/expected):%s", results_seen, diffs));
    endtask

    // Channel monitor: register writes, then results, then new samples
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain    = AR_GAIN_RST;
            q_state = STATE_NOISE_RST;
            r_obs   = OBS_NOISE_RST;
            offset  = OBS_OFFSET_RST;
            p_init  = INITIAL_VAR_RST;
            mean_q  = '0;
            var_q   = INITIAL_VAR_RST;
            estimates.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                advance_filter(in_data);
            outstanding = estimates.size();
        end
    end

endmodule

// File: test/tb_scalar_kalman_forward_filter.sv
`timescale 1ns / 100ps

module tb_scalar_kalman_forward_filter;
    import kal_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int IDLE_PCT    = 31;
    localparam int RX_HOLD     = 150;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = FRAC_BITS + 16;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 48;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    kal_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    kal_out_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_AR_GAIN;
    logic [31:0]          cfg_data  = '0;

    int fail_count;
    int pending;
    bit calm         = 1'b0;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    scalar_kalman_forward_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kalman_filter_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side: random back-pressure, long hold-off on request, none when calm
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = RX_HOLD - 1;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Q16.16 values: mostly within ten units either side of zero, some full range
    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $signed($urandom);
            default: return $signed(32'($urandom_range(32'h0014_0000)) - 32'h000A_0000);
        endcase
    endfunction

    // Drive is usually absent, occasionally a spike
    function automatic logic signed [31:0] rand_drive();
        return ($urandom_range(9) < 6) ? 32'sd0 : rand_q16();
    endfunction

    function automatic logic [31:0] rand_reg(input logic [CFG_IDX_W-1:0] idx);
        int unsigned pick;
        pick = $urandom_range(9);
        case (idx)
            REG_AR_GAIN:
                case (pick)
                    0:       return 32'd0;
                    1:       return 32'd65536;
                    2:       return 32'($urandom_range(131071, 65537));
                    3:       return 32'($urandom_range(65536));
                    default: return 32'($urandom_range(65536, 49152));
                endcase
            REG_OBS_OFFSET:
                case (pick)
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2, 3:    return $urandom;
                    default: return 32'($urandom_range(32'h0014_0000)) - 32'h000A_0000;
                endcase
            REG_OBS_NOISE:
                case (pick)
                    0:       return 32'd1;
                    1:       return 32'h7FFF_FFFF;
                    2, 3:    return ($urandom & 32'h7FFF_FFFF) | 32'd1;
                    default: return 32'($urandom_range(32'h0010_0000, 1));
                endcase
            default:
                case (pick)
                    0:       return 32'd0;
                    1:       return 32'h7FFF_FFFF;
                    2, 3:    return $urandom & 32'h7FFF_FFFF;
                    default: return 32'($urandom_range(32'h0010_0000));
                endcase
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_sample(input logic signed [31:0] s, input logic signed [31:0] d,
                               input logic f);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data  <= '{sample: s, drive: d, first: f};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until every estimate has been matched
    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int  n;
        int  run_len;
        logic f;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: restart, ordinary steps, clipping in both directions
        send_sample(32'sd0, 32'sd0, 1'b1);
        send_sample(32'sd65536, 32'sd0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 32'sd0, 1'b0);
        send_sample(32'sh7FFF_FFFF, 32'sd0, 1'b1);
        send_sample(-32'sd1, -32'sd1, 1'b0);
        send_sample(32'sd12345, -32'sd65536, 1'b0);
        wait_results();

        // Gain above one, largest noise and start variance, smallest obs noise
        write_reg(REG_AR_GAIN, 32'd131071);
        write_reg(REG_STATE_NOISE, 32'h7FFF_FFFF);
        write_reg(REG_OBS_NOISE, 32'd1);
        write_reg(REG_OBS_OFFSET, 32'h8000_0000);
        write_reg(REG_INITIAL_VAR, 32'h7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF, 32'sd0, 1'b1);
        send_sample(32'sd0, 32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_sample(32'sd0, 32'sd0, 1'b0);
        send_sample(32'sh8000_0000, 32'sd0, 1'b1);
        wait_results();

        // Zero denominator: no gain, no noise, zero start variance
        write_reg(REG_AR_GAIN, 32'd0);
        write_reg(REG_STATE_NOISE, 32'd0);
        write_reg(REG_OBS_NOISE, 32'd0);
        write_reg(REG_OBS_OFFSET, 32'h7FFF_FFFF);
        write_reg(REG_INITIAL_VAR, 32'd0);
        send_sample(32'sd1, 32'sd5, 1'b1);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        wait_results();

        // Unit gain with noiseless observations: full correction, variance 0
        write_reg(REG_AR_GAIN, 32'd65536);
        write_reg(REG_STATE_NOISE, 32'd65536);
        send_sample(32'sd65536, 32'sd0, 1'b1);
        send_sample(-32'sd65536, 32'sd65536, 1'b0);
        wait_results();

        // Random settings, each phase a run of restarted sequences
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_reg(REG_AR_GAIN, rand_reg(REG_AR_GAIN));
            write_reg(REG_STATE_NOISE, rand_reg(REG_STATE_NOISE));
            write_reg(REG_OBS_NOISE, rand_reg(REG_OBS_NOISE));
            write_reg(REG_OBS_OFFSET, rand_reg(REG_OBS_OFFSET));
            write_reg(REG_INITIAL_VAR, rand_reg(REG_INITIAL_VAR));
            calm = (ph == 3);
            if (ph == 1)
                hold_reqs++;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                run_len = $urandom_range(24, 1);
                for (int j = 0; j < run_len && n < PHASE_ITEMS; j++)
                begin
                    if (ph == 5 && n == PHASE_ITEMS / 2)
                        wait_results();
                    // mostly well-formed: restart at the head of a run only
                    if (j == 0)
                        f = ($urandom_range(9) != 0);
                    else
                        f = ($urandom_range(9) == 0);
                    send_sample(rand_q16(), rand_drive(), f);
                    n++;
                end
            end
            wait_results();
        end
        calm = 1'b0;

        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
